@@ design/wfs_pkg.sv @@
package wfs_pkg;

	// Fixed-point format and field widths.
	localparam int FRAC_BITS       = 16;
	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int COL_W           = 11;
	localparam int ROW_W           = 16;
	localparam int IDX_W           = 3;
	localparam int DATA_W          = 32;
	localparam int Q_W             = 31;
	localparam int U_W             = 22;
	localparam int R_W             = 24;
	localparam int TERM_W          = 42;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [16:0]       LOG2E_Q16  = 17'd94548;
	localparam logic [U_W-1:0]    U_LIMIT    = U_W'(32 << FRAC_BITS);
	localparam logic [TERM_W-2:0] TERM_LIMIT = (TERM_W-1)'(64'd1 << 40);

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		CFG_GRID_WIDTH  = 3'd0,
		CFG_GRID_ROWS   = 3'd1,
		CFG_X_STEP      = 3'd2,
		CFG_T_STEP_SQ   = 3'd3,
		CFG_SOURCE_RATE = 3'd4,
		CFG_X_OFFSET    = 3'd5,
		CFG_T_OFFSET    = 3'd6
	} cfg_index_t;

	// One unit of work handed from the front part to the back part.
	typedef struct packed {
		logic                    restart;
		logic [COL_W-1:0]        column;
		logic [ROW_W-1:0]        row;
		logic                    bank;
		logic                    last;
		logic                    right_zero;
		logic signed [DATA_W-1:0] x_dist;
		logic signed [DATA_W-1:0] t_dist;
	} work_t;

	// Table of 2^(-k/16) in Q16 for k = 0 .. 16.
	function automatic logic [16:0] pow2_neg(input logic [4:0] k);
		logic [16:0] v;
		begin
			case (k)
				5'd0:    v = 17'd65536;
				5'd1:    v = 17'd62757;
				5'd2:    v = 17'd60097;
				5'd3:    v = 17'd57549;
				5'd4:    v = 17'd55109;
				5'd5:    v = 17'd52773;
				5'd6:    v = 17'd50535;
				5'd7:    v = 17'd48393;
				5'd8:    v = 17'd46341;
				5'd9:    v = 17'd44376;
				5'd10:   v = 17'd42495;
				5'd11:   v = 17'd40693;
				5'd12:   v = 17'd38968;
				5'd13:   v = 17'd37316;
				5'd14:   v = 17'd35734;
				5'd15:   v = 17'd34219;
				default: v = 17'd32768;
			endcase
			return v;
		end
	endfunction

	// Signed 32-bit value plus unsigned 31-bit step, saturated at the top.
	function automatic logic signed [DATA_W-1:0] sat_add(
		input logic signed [DATA_W-1:0] a,
		input logic [Q_W-1:0]           b
	);
		logic signed [DATA_W:0] s;
		begin
			s = $signed({a[DATA_W-1], a}) + $signed({2'b00, b});
			if (s > $signed({2'b00, {(DATA_W-1){1'b1}}})) begin
				return {1'b0, {(DATA_W-1){1'b1}}};
			end
			return s[DATA_W-1:0];
		end
	endfunction

endpackage

@@ design/wfs_ricker.sv @@
module wfs_ricker (
	input  logic                             clk,
	input  logic                             en,
	input  logic [wfs_pkg::Q_W-1:0]          source_rate,
	input  logic signed [wfs_pkg::DATA_W-1:0] distance,
	output logic signed [wfs_pkg::R_W-1:0]    ricker
);
	import wfs_pkg::*;

	logic [46:0]        dd_s1;
	logic [62:0]        pl_s2;
	logic [45:0]        ph_s2;
	logic [U_W-1:0]     u_s3, u_s4, u_s5, u_s6;
	logic [22:0]        v_s4;
	logic [16:0]        t0_s5;
	logic [28:0]        dl_s5;
	logic [6:0]         ip_s5;
	logic [16:0]        e_s6;
	logic signed [R_W-1:0] ricker_s7;

	logic [31:0] mag;
	logic [63:0] sq;
	logic [77:0] prod3;
	logic [61:0] uw;
	logic [38:0] vm;
	logic [3:0]  idx;
	logic [11:0] rem;
	logic [16:0] t0, t1, e0;
	logic signed [R_W-1:0] a7;
	logic [R_W-1:0] amag;
	logic [40:0] prod7;
	logic [R_W-1:0] m7;

	// Distance squared, then source rate times it split into two partial products.
	always_comb begin
		mag   = distance[DATA_W-1] ? (~distance + 32'd1) : distance;
		sq    = mag * mag;
		prod3 = {ph_s2, 32'd0} + {15'd0, pl_s2};
		uw    = prod3[77:FRAC_BITS];
		vm    = u_s3 * LOG2E_Q16;
	end

	// Table lookup with linear interpolation of 2^-f.
	always_comb begin
		idx = v_s4[15:12];
		rem = v_s4[11:0];
		t0  = pow2_neg({1'b0, idx});
		t1  = pow2_neg(5'({1'b0, idx}) + 5'd1);
		e0  = t0_s5 - 17'(dl_s5 >> 12);
	end

	// (1 - 2u) times exp(-u), truncated toward zero.
	always_comb begin
		a7    = R_W'(65536) - $signed({1'b0, u_s6, 1'b0});
		amag  = a7[R_W-1] ? R_W'(-a7) : R_W'(a7);
		prod7 = amag * e_s6;
		m7    = prod7[R_W+FRAC_BITS-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s1     <= sq[62:FRAC_BITS];
			pl_s2     <= source_rate * dd_s1[31:0];
			ph_s2     <= source_rate * dd_s1[46:32];
			u_s3      <= (uw > 62'(U_LIMIT)) ? U_LIMIT : uw[U_W-1:0];
			u_s4      <= u_s3;
			v_s4      <= vm[38:FRAC_BITS];
			u_s5      <= u_s4;
			t0_s5     <= t0;
			dl_s5     <= 29'(t0 - t1) * 29'(rem);
			ip_s5     <= v_s4[22:16];
			u_s6      <= u_s5;
			e_s6      <= (ip_s5 > 7'd16) ? 17'd0 : (e0 >> ip_s5);
			ricker_s7 <= a7[R_W-1] ? -$signed(m7) : $signed(m7);
		end
	end

	assign ricker = ricker_s7;

endmodule

@@ design/wfs_front.sv @@
module wfs_front #(
	parameter int MAX_COLUMNS = wfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              restart,
	input  logic [wfs_pkg::COL_W-1:0]         grid_width,
	input  logic [wfs_pkg::ROW_W-1:0]         grid_rows,
	input  logic [wfs_pkg::Q_W-1:0]           x_step,
	input  logic signed [wfs_pkg::DATA_W-1:0] x_offset_from_peak,
	input  logic signed [wfs_pkg::DATA_W-1:0] t_offset_from_peak,
	input  logic                              queue_full,
	output logic                              push,
	output wfs_pkg::work_t                    push_work
);
	import wfs_pkg::*;

	logic [ROW_W-1:0]         row_q;
	logic [COL_W-1:0]         col_q;
	logic                     bank_q;
	logic signed [DATA_W-1:0] xd_q, td_q;

	logic [COL_W-1:0]         w, c1, c2;
	logic [ROW_W-1:0]         r1;
	logic                     b1, too_small, wrap_pre, wrap_post, stop, emit, accept;
	logic signed [DATA_W-1:0] xd1, td1;
	logic [Q_W-1:0]           half;

	// Effective width and the row change that precedes a cell.
	always_comb begin
		w = (32'(grid_width) > MAX_COLUMNS) ? COL_W'(MAX_COLUMNS) : grid_width;
		too_small = w < COL_W'(3);
		half = {1'b0, x_step[Q_W-1:1]};
		wrap_pre = (col_q == '0) ||
			((COL_W+1)'(col_q) + (COL_W+1)'(1) >= (COL_W+1)'(w));
		r1  = wrap_pre ? row_q + ROW_W'(1) : row_q;
		c1  = wrap_pre ? COL_W'(1) : col_q;
		xd1 = wrap_pre ? x_offset_from_peak : xd_q;
		td1 = wrap_pre ? sat_add(td_q, half) : td_q;
		b1  = wrap_pre ? ~bank_q : bank_q;
		stop = ((ROW_W+1)'(r1) + (ROW_W+1)'(1)) >= (ROW_W+1)'(grid_rows);
		emit = !too_small && !stop;
		c2 = c1 + COL_W'(1);
		wrap_post = (COL_W+1)'(c2) + (COL_W+1)'(1) >= (COL_W+1)'(w);
	end

	// The work item for the back part.
	always_comb begin
		accept = req_valid && req_ready;
		push   = accept && (restart || emit);
		push_work.restart    = restart;
		push_work.column     = c1;
		push_work.row        = r1 + ROW_W'(1);
		push_work.bank       = b1;
		push_work.last       = (((ROW_W+1)'(r1) + (ROW_W+1)'(2)) == (ROW_W+1)'(grid_rows)) &&
			(((COL_W+1)'(c1) + (COL_W+1)'(2)) == (COL_W+1)'(w));
		push_work.right_zero = ((COL_W+1)'(c1) + (COL_W+1)'(2)) >= (COL_W+1)'(w);
		push_work.x_dist     = xd1;
		push_work.t_dist     = td1;
	end

	assign req_ready = !queue_full;

	// Grid position and source distances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= ROW_W'(1);
			col_q  <= COL_W'(1);
			bank_q <= 1'b0;
			xd_q   <= '0;
			td_q   <= '0;
		end else if (accept) begin
			if (restart) begin
				row_q  <= ROW_W'(1);
				col_q  <= COL_W'(1);
				bank_q <= 1'b0;
				xd_q   <= x_offset_from_peak;
				td_q   <= t_offset_from_peak;
			end else if (!too_small) begin
				if (!emit) begin
					row_q  <= r1;
					col_q  <= c1;
					bank_q <= b1;
					xd_q   <= xd1;
					td_q   <= td1;
				end else if (wrap_post) begin
					row_q  <= r1 + ROW_W'(1);
					col_q  <= COL_W'(1);
					bank_q <= ~b1;
					xd_q   <= x_offset_from_peak;
					td_q   <= sat_add(td1, half);
				end else begin
					row_q  <= r1;
					col_q  <= c2;
					bank_q <= b1;
					xd_q   <= sat_add(xd1, x_step);
					td_q   <= td1;
				end
			end
		end
	end

endmodule

@@ design/wfs_queue.sv @@
module wfs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wfs_pkg::work_t push_work,
	output logic           full,
	output logic           head_valid,
	input  logic           pop,
	output wfs_pkg::work_t head
);
	import wfs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	work_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_work;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

@@ design/wfs_back.sv @@
module wfs_back #(
	parameter int MAX_COLUMNS = wfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  wfs_pkg::work_t                    head,
	output logic                              pop,
	input  logic [wfs_pkg::Q_W-1:0]           t_step_sq,
	input  logic [wfs_pkg::Q_W-1:0]           source_rate,
	output logic                              cell_valid,
	input  logic                              cell_ready,
	output logic signed [wfs_pkg::DATA_W-1:0] cell_value,
	output logic [wfs_pkg::ROW_W-1:0]         row_index,
	output logic [9:0]                        column_index,
	output logic                              last_cell
);
	import wfs_pkg::*;

	localparam int AW     = $clog2(MAX_COLUMNS);
	localparam int NSTAGE = 9;

	logic                     valid_s [1:NSTAGE];
	work_t                    work_s  [1:NSTAGE];
	logic signed [R_W-1:0]    rt_s7, rx_s7;
	logic signed [DATA_W-1:0] p_s8;
	logic signed [TERM_W-1:0] term_s9;
	logic signed [DATA_W-1:0] rd_a0_s9, rd_a1_s9, rd_b0_s9, rd_b1_s9;

	logic signed [DATA_W-1:0] bank_a_mem [MAX_COLUMNS];
	logic signed [DATA_W-1:0] bank_b_mem [MAX_COLUMNS];

	logic [AW-1:0]            fill_a_q, fill_b_q;
	logic                     lw_valid_q, lw_bank_q;
	logic [AW-1:0]            lw_addr_q;
	logic signed [DATA_W-1:0] lw_data_q, left_q;

	logic                     cell_valid_q, last_q;
	logic signed [DATA_W-1:0] value_q;
	logic [ROW_W-1:0]         row_q;
	logic [9:0]               col_q;

	logic                     adv, retire_cell, retire_restart;
	logic [AW-1:0]            rd_addr0, rd_addr1, j_a, j1_a, fill_cur, fill_dst;
	logic [R_W-1:0]           mag_t, mag_x;
	logic [2*R_W-1:0]         prod8;
	logic [DATA_W-1:0]        mag_p;
	logic [62:0]              prod9;
	logic [46:0]              m9;
	logic [DATA_W-1:0]        m8;
	logic                     cur_bank, dst_bank;
	logic signed [DATA_W-1:0] cur_raw0, cur_raw1, dst_raw, cur_mid, cur_right, prev, left;
	logic signed [34:0]       lap, lap_adj, lap4;
	logic signed [43:0]       sum;
	logic signed [DATA_W-1:0] new_value;

	assign adv = !cell_valid_q || cell_ready;
	assign pop = adv && head_valid;

	// Source wavelet in time and in space.
	wfs_ricker u_ricker_t (
		.clk         (clk),
		.en          (adv),
		.source_rate (source_rate),
		.distance    (head.t_dist),
		.ricker      (rt_s7)
	);

	wfs_ricker u_ricker_x (
		.clk         (clk),
		.en          (adv),
		.source_rate (source_rate),
		.distance    (head.x_dist),
		.ricker      (rx_s7)
	);

	// Product of the two wavelets, then the time-step weight with its limit.
	always_comb begin
		mag_t = rt_s7[R_W-1] ? R_W'(-rt_s7) : R_W'(rt_s7);
		mag_x = rx_s7[R_W-1] ? R_W'(-rx_s7) : R_W'(rx_s7);
		prod8 = mag_t * mag_x;
		m8    = prod8[2*R_W-1:FRAC_BITS];
		mag_p = p_s8[DATA_W-1] ? (~p_s8 + 32'sd1) : p_s8;
		prod9 = t_step_sq * mag_p;
		m9    = prod9[62:FRAC_BITS];
	end

	// Payload registers of the pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			work_s[1] <= head;
			for (int i = 2; i <= NSTAGE; i++) begin
				work_s[i] <= work_s[i-1];
			end
			p_s8 <= (rt_s7[R_W-1] ^ rx_s7[R_W-1]) ? -$signed(m8) : $signed(m8);
			if (m9 > 47'(TERM_LIMIT)) begin
				term_s9 <= p_s8[DATA_W-1] ? -$signed({1'b0, TERM_LIMIT})
					: $signed({1'b0, TERM_LIMIT});
			end else begin
				term_s9 <= p_s8[DATA_W-1] ? -$signed({1'b0, m9[TERM_W-2:0]})
					: $signed({1'b0, m9[TERM_W-2:0]});
			end
		end
	end

	// Row banks: two reads a cycle for the next stage, one write at retire.
	assign rd_addr0 = AW'(work_s[8].column);
	assign rd_addr1 = AW'(work_s[8].column + COL_W'(1));

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_a0_s9 <= bank_a_mem[rd_addr0];
			rd_a1_s9 <= bank_a_mem[rd_addr1];
			rd_b0_s9 <= bank_b_mem[rd_addr0];
			rd_b1_s9 <= bank_b_mem[rd_addr1];
			if (retire_cell && !dst_bank) begin
				bank_a_mem[j_a] <= new_value;
			end
			if (retire_cell && dst_bank) begin
				bank_b_mem[j_a] <= new_value;
			end
		end
	end

	// Stencil sum. Entries past the fill mark read as zero; the
	// most recent write is forwarded since the read may not have seen it.
	always_comb begin
		retire_cell    = valid_s[NSTAGE] && !work_s[NSTAGE].restart;
		retire_restart = valid_s[NSTAGE] && work_s[NSTAGE].restart;
		cur_bank = work_s[NSTAGE].bank;
		dst_bank = ~cur_bank;
		j_a      = AW'(work_s[NSTAGE].column);
		j1_a     = AW'(work_s[NSTAGE].column + COL_W'(1));
		cur_raw0 = cur_bank ? rd_b0_s9 : rd_a0_s9;
		cur_raw1 = cur_bank ? rd_b1_s9 : rd_a1_s9;
		dst_raw  = cur_bank ? rd_a0_s9 : rd_b0_s9;
		fill_cur = cur_bank ? fill_b_q : fill_a_q;
		fill_dst = cur_bank ? fill_a_q : fill_b_q;

		if (lw_valid_q && lw_bank_q == cur_bank && lw_addr_q == j_a) begin
			cur_mid = lw_data_q;
		end else begin
			cur_mid = (j_a <= fill_cur) ? cur_raw0 : '0;
		end

		if (work_s[NSTAGE].right_zero) begin
			cur_right = '0;
		end else if (lw_valid_q && lw_bank_q == cur_bank && lw_addr_q == j1_a) begin
			cur_right = lw_data_q;
		end else begin
			cur_right = (j1_a <= fill_cur) ? cur_raw1 : '0;
		end

		if (lw_valid_q && lw_bank_q == dst_bank && lw_addr_q == j_a) begin
			prev = lw_data_q;
		end else begin
			prev = (j_a <= fill_dst) ? dst_raw : '0;
		end

		left = (work_s[NSTAGE].column == COL_W'(1)) ? '0 : left_q;

		lap = {{3{left[DATA_W-1]}}, left} - {{2{cur_mid[DATA_W-1]}}, cur_mid, 1'b0}
			+ {{3{cur_right[DATA_W-1]}}, cur_right};
		lap_adj = lap + {33'd0, {2{lap[34]}}};
		lap4    = lap_adj >>> 2;
		sum = {{9{lap4[34]}}, lap4} + {{11{cur_mid[DATA_W-1]}}, cur_mid, 1'b0}
			- {{12{prev[DATA_W-1]}}, prev} + {{2{term_s9[TERM_W-1]}}, term_s9};
		if (sum > 44'sh0007FFFFFFF) begin
			new_value = 32'sh7FFFFFFF;
		end else if (sum < -44'sh00080000000) begin
			new_value = -32'sh80000000;
		end else begin
			new_value = sum[DATA_W-1:0];
		end
	end

	// Window value and result payload.
	always_ff @(posedge clk) begin
		if (adv && retire_cell) begin
			left_q    <= cur_mid;
			lw_bank_q <= dst_bank;
			lw_addr_q <= j_a;
			lw_data_q <= new_value;
			value_q   <= new_value;
			row_q     <= work_s[NSTAGE].row;
			col_q     <= work_s[NSTAGE].column[9:0];
			last_q    <= work_s[NSTAGE].last;
		end
	end

	// Stage valid bits, fill marks and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NSTAGE; i++) begin
				valid_s[i] <= 1'b0;
			end
			fill_a_q     <= '0;
			fill_b_q     <= '0;
			lw_valid_q   <= 1'b0;
			cell_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s[1] <= head_valid;
			for (int i = 2; i <= NSTAGE; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
			cell_valid_q <= retire_cell;
			if (retire_restart) begin
				fill_a_q   <= '0;
				fill_b_q   <= '0;
				lw_valid_q <= 1'b0;
			end else if (retire_cell) begin
				lw_valid_q <= 1'b1;
				if (!dst_bank && j_a > fill_a_q) begin
					fill_a_q <= j_a;
				end
				if (dst_bank && j_a > fill_b_q) begin
					fill_b_q <= j_a;
				end
			end
		end
	end

	assign cell_valid   = cell_valid_q;
	assign cell_value   = value_q;
	assign row_index    = row_q;
	assign column_index = col_q;
	assign last_cell    = last_q;

`ifndef SYNTHESIS
	a_restart_clears_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv && retire_restart |=> fill_a_q == '0 && fill_b_q == '0 && !lw_valid_q)
		else $error("fill marks not cleared by restart");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && valid_s[NSTAGE] |=> valid_s[NSTAGE])
		else $error("last stage lost its work during a stall");

	a_retire_column: assert property (@(posedge clk) disable iff (!arst_n)
		adv && retire_cell |=> cell_valid_q && col_q != '0)
		else $error("retired cell has no valid result or column zero");
`endif

endmodule

@@ design/wave_1d_fdtd_stencil.sv @@
// 1-D wave equation stepper with a Ricker wavelet source, Q16.16 fixed point.
//
// Request channel (req_valid/req_ready, field restart): restart = 1 clears the
// grid, the counters and the source distances and yields no result;
// restart = 0 asks for the next interior cell. A request yields no result when
// the grid is done or the width is below three.
// Result channel (cell_valid/cell_ready): the new cell value, saturated to
// 32 bits, with its row, its column and a flag on the final grid cell.
// Configuration: write_enable, write_index and write_data, taken at the edge.
// The user must write only while the block is idle; the block does not check.
// A request is queued, then passes the back pipeline and the result register;
// one request and one result are taken every cycle while nothing stalls, set
// by the front stepping the grid once per cycle and two read ports per bank.
// Reset clears the registers to their listed reset values and the row banks
// read as zero through per-bank fill marks, so no clearing pass is needed.
// When the receiver stalls, the back pipeline holds, the four-entry queue
// fills and req_ready falls.
module wave_1d_fdtd_stencil #(
	parameter int MAX_COLUMNS = wfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              write_enable,
	input  logic [wfs_pkg::IDX_W-1:0]         write_index,
	input  logic [wfs_pkg::DATA_W-1:0]        write_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              restart,
	output logic                              cell_valid,
	input  logic                              cell_ready,
	output logic signed [wfs_pkg::DATA_W-1:0] cell_value,
	output logic [wfs_pkg::ROW_W-1:0]         row_index,
	output logic [9:0]                        column_index,
	output logic                              last_cell
);
	import wfs_pkg::*;

	logic [COL_W-1:0]         grid_width_q;
	logic [ROW_W-1:0]         grid_rows_q;
	logic [Q_W-1:0]           x_step_q, t_step_sq_q, source_rate_q;
	logic signed [DATA_W-1:0] x_offset_q, t_offset_q;

	logic  push, queue_full, head_valid, pop;
	work_t push_work, head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= COL_W'(1024);
			grid_rows_q   <= ROW_W'(1024);
			x_step_q      <= Q_W'(65536);
			t_step_sq_q   <= Q_W'(16384);
			source_rate_q <= Q_W'(65536);
			x_offset_q    <= '0;
			t_offset_q    <= '0;
		end else if (write_enable) begin
			case (write_index)
				CFG_GRID_WIDTH:  grid_width_q  <= write_data[COL_W-1:0];
				CFG_GRID_ROWS:   grid_rows_q   <= write_data[ROW_W-1:0];
				CFG_X_STEP:      x_step_q      <= write_data[Q_W-1:0];
				CFG_T_STEP_SQ:   t_step_sq_q   <= write_data[Q_W-1:0];
				CFG_SOURCE_RATE: source_rate_q <= write_data[Q_W-1:0];
				CFG_X_OFFSET:    x_offset_q    <= write_data;
				CFG_T_OFFSET:    t_offset_q    <= write_data;
				default: ;
			endcase
		end
	end

	wfs_front #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_ready          (req_ready),
		.restart            (restart),
		.grid_width         (grid_width_q),
		.grid_rows          (grid_rows_q),
		.x_step             (x_step_q),
		.x_offset_from_peak (x_offset_q),
		.t_offset_from_peak (t_offset_q),
		.queue_full         (queue_full),
		.push               (push),
		.push_work          (push_work)
	);

	wfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_work  (push_work),
		.full       (queue_full),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	wfs_back #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.t_step_sq    (t_step_sq_q),
		.source_rate  (source_rate_q),
		.cell_valid   (cell_valid),
		.cell_ready   (cell_ready),
		.cell_value   (cell_value),
		.row_index    (row_index),
		.column_index (column_index),
		.last_cell    (last_cell)
	);

endmodule

@@ verif/wave_1d_fdtd_stencil_checker.sv @@
`timescale 1ns / 1ps

module wave_1d_fdtd_stencil_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              write_enable,
	input  logic [wfs_pkg::IDX_W-1:0]         write_index,
	input  logic [wfs_pkg::DATA_W-1:0]        write_data,
	input  logic                              req_valid,
	input  logic                              req_ready,
	input  logic                              restart,
	input  logic                              cell_valid,
	input  logic                              cell_ready,
	input  logic signed [wfs_pkg::DATA_W-1:0] cell_value,
	input  logic [wfs_pkg::ROW_W-1:0]         row_index,
	input  logic [9:0]                        column_index,
	input  logic                              last_cell,
	output int                                errors,
	output int                                pending
);
	import wfs_pkg::*;

	localparam int GRID_MAX = 1024;

	typedef struct {
		logic signed [31:0] value;
		logic [15:0]        row;
		logic [9:0]         col;
		logic               last;
	} cell_t;

	cell_t expected_cells[$];

	// Q16 table of 2^(-k/16).
	logic [16:0] exp2_frac_tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
		48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	// Register copies.
	logic [10:0]        width_r;
	logic [15:0]        rows_r;
	logic [30:0]        xstep_r, tsq_r, rate_r;
	logic signed [31:0] xoff_r, toff_r;

	// Grid state.
	logic signed [31:0] bank_a [GRID_MAX];
	logic signed [31:0] bank_b [GRID_MAX];
	logic               sel;
	logic [15:0]        row_cnt;
	int unsigned        col_cnt;
	logic signed [31:0] x_dist, t_dist;

	// Exact product shifted right by the fraction bits, magnitude limited to 2^62.
	function automatic longint fx_mul(input longint a, input longint b);
		logic [127:0] ua, ub, p;
		logic         neg;
		begin
			neg = (a < 0) != (b < 0);
			ua = a < 0 ? 128'(-a) : 128'(a);
			ub = b < 0 ? 128'(-b) : 128'(b);
			p = (ua * ub) >> FRAC_BITS;
			if (p > (128'd1 << 62)) begin
				p = 128'd1 << 62;
			end
			return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
		end
	endfunction

	// exp(-u) through a base-2 table with linear interpolation.
	function automatic longint exp_neg(input longint u);
		logic [63:0] v, ip, frac, rem, t0, t1, e;
		int          k;
		begin
			v = (64'(u) * 64'd94548) >> 16;
			ip = v >> FRAC_BITS;
			frac = v & 64'hFFFF;
			k = int'(frac >> 12);
			rem = frac & 64'hFFF;
			t0 = 64'(exp2_frac_tab[k]);
			t1 = 64'(exp2_frac_tab[k + 1]);
			e = t0 - (((t0 - t1) * rem) >> 12);
			if (ip > FRAC_BITS) begin
				return 0;
			end
			return longint'(e >> ip);
		end
	endfunction

	function automatic longint ricker(input logic signed [31:0] d);
		longint u;
		begin
			u = fx_mul(longint'(rate_r), fx_mul(longint'(d), longint'(d)));
			if (u > (longint'(32) << FRAC_BITS)) begin
				u = longint'(32) << FRAC_BITS;
			end
			return fx_mul((longint'(1) << FRAC_BITS) - 2 * u, exp_neg(u));
		end
	endfunction

	function automatic logic signed [31:0] sat32(input longint v);
		begin
			if (v > 64'sh7FFFFFFF) begin
				return 32'sh7FFFFFFF;
			end
			if (v < -64'sh80000000) begin
				return 32'sh80000000;
			end
			return v[31:0];
		end
	endfunction

	function automatic longint read_row(input longint j, input longint w);
		begin
			if (j == 0 || j + 1 >= w || j >= GRID_MAX) begin
				return 0;
			end
			return sel ? longint'(bank_b[j]) : longint'(bank_a[j]);
		end
	endfunction

	task automatic advance_row();
		row_cnt = row_cnt + 16'd1;
		col_cnt = 1;
		x_dist = xoff_r;
		t_dist = sat32(longint'(t_dist) + longint'(xstep_r >> 1));
		sel = ~sel;
	endtask

	task automatic clear_grid();
		for (int i = 0; i < GRID_MAX; i++) begin
			bank_a[i] = 0;
			bank_b[i] = 0;
		end
		sel = 1'b0;
		row_cnt = 16'd1;
		col_cnt = 1;
		x_dist = xoff_r;
		t_dist = toff_r;
	endtask

	// Work out the cell that one request yields, if any.
	task automatic predict_cell(input logic clear);
		longint w, j, cur, lap, prev, term;
		cell_t  c;
		begin
			w = width_r > GRID_MAX ? GRID_MAX : longint'(width_r);
			if (clear) begin
				clear_grid();
			end else if (w >= 3) begin
				if (col_cnt == 0 || col_cnt + 1 >= w) begin
					advance_row();
				end
				if (longint'(row_cnt) + 1 < longint'(rows_r)) begin
					j = col_cnt;
					cur = read_row(j, w);
					lap = read_row(j - 1, w) - 2 * cur + read_row(j + 1, w);
					prev = sel ? longint'(bank_a[j]) : longint'(bank_b[j]);
					term = fx_mul(longint'(tsq_r), fx_mul(ricker(t_dist), ricker(x_dist)));
					if (term > (longint'(1) << 40)) begin
						term = longint'(1) << 40;
					end
					if (term < -(longint'(1) << 40)) begin
						term = -(longint'(1) << 40);
					end
					c.value = sat32(lap / 4 + 2 * cur - prev + term);
					if (sel) begin
						bank_a[j] = c.value;
					end else begin
						bank_b[j] = c.value;
					end
					c.row = row_cnt + 16'd1;
					c.col = j[9:0];
					c.last = (longint'(row_cnt) + 2 == longint'(rows_r)) && (j + 2 == w);
					expected_cells.push_back(c);
					x_dist = sat32(longint'(x_dist) + longint'(xstep_r));
					col_cnt = j + 1;
					if (col_cnt + 1 >= w) begin
						advance_row();
					end
				end
			end
		end
	endtask

	// Follow register writes, requests and results.
	always @(posedge clk or negedge arst_n) begin
		cell_t c;
		if (!arst_n) begin
			width_r = 11'd1024;
			rows_r = 16'd1024;
			xstep_r = 31'd65536;
			tsq_r = 31'd16384;
			rate_r = 31'd65536;
			xoff_r = 0;
			toff_r = 0;
			clear_grid();
			expected_cells.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (write_enable) begin
				case (cfg_index_t'(write_index))
					CFG_GRID_WIDTH:  width_r = write_data[10:0];
					CFG_GRID_ROWS:   rows_r = write_data[15:0];
					CFG_X_STEP:      xstep_r = write_data[30:0];
					CFG_T_STEP_SQ:   tsq_r = write_data[30:0];
					CFG_SOURCE_RATE: rate_r = write_data[30:0];
					CFG_X_OFFSET:    xoff_r = write_data;
					CFG_T_OFFSET:    toff_r = write_data;
					default:         ;
				endcase
			end
			if (req_valid && req_ready) begin
				predict_cell(restart);
			end
			if (cell_valid && cell_ready) begin
				if (expected_cells.size() == 0) begin
					$error("unexpected cell: value %0d row %0d column %0d", cell_value,
						row_index, column_index);
					errors++;
				end else begin
					c = expected_cells.pop_front();
					if (cell_value !== c.value) begin
						$error("cell_value: expected %0d, got %0d", c.value, cell_value);
						errors++;
					end
					if (row_index !== c.row) begin
						$error("row_index: expected %0d, got %0d", c.row, row_index);
						errors++;
					end
					if (column_index !== c.col) begin
						$error("column_index: expected %0d, got %0d", c.col, column_index);
						errors++;
					end
					if (last_cell !== c.last) begin
						$error("last_cell: expected %0d, got %0d", c.last, last_cell);
						errors++;
					end
				end
			end
			pending = expected_cells.size();
		end
	end

endmodule

@@ verif/wave_1d_fdtd_stencil_tb.sv @@
`timescale 1ns / 1ps

module wave_1d_fdtd_stencil_tb;
	import wfs_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic                     clk;
	logic                     arst_n;
	logic                     write_enable;
	logic [IDX_W-1:0]         write_index;
	logic [DATA_W-1:0]        write_data;
	logic                     req_valid;
	logic                     req_ready;
	logic                     restart;
	logic                     cell_valid;
	logic                     cell_ready;
	logic signed [DATA_W-1:0] cell_value;
	logic [ROW_W-1:0]         row_index;
	logic [9:0]               column_index;
	logic                     last_cell;
	int                       errors;
	int                       pending;
	logic                     calm;
	int                       quiet_cycles;

	wave_1d_fdtd_stencil uut (
		.clk(clk), .arst_n(arst_n), .write_enable(write_enable), .write_index(write_index),
		.write_data(write_data), .req_valid(req_valid), .req_ready(req_ready),
		.restart(restart), .cell_valid(cell_valid), .cell_ready(cell_ready),
		.cell_value(cell_value), .row_index(row_index), .column_index(column_index),
		.last_cell(last_cell)
	);

	wave_1d_fdtd_stencil_checker checker_i (
		.clk(clk), .arst_n(arst_n), .write_enable(write_enable), .write_index(write_index),
		.write_data(write_data), .req_valid(req_valid), .req_ready(req_ready),
		.restart(restart), .cell_valid(cell_valid), .cell_ready(cell_ready),
		.cell_value(cell_value), .row_index(row_index), .column_index(column_index),
		.last_cell(last_cell), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls in random bursts, none in the calm part of the run.
	initial begin
		cell_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 15) == 0) begin
				cell_ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			cell_ready = 1'b1;
			repeat ($urandom_range(0, 30)) @(negedge clk);
		end
	end

	// Watchdog on cycles with no request and no result taken.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (cell_valid && cell_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("wave_1d_fdtd_stencil: mismatch");
			$finish;
		end
	end

	// Send one request; valid stays high afterwards until the next call or a drop.
	task automatic send_request(input logic clear);
		if (!calm && $urandom_range(0, 12) == 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		req_valid = 1'b1;
		restart = clear;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
		@(negedge clk);
		write_enable = 1'b1;
		write_index = idx;
		write_data = data;
		@(negedge clk);
		write_enable = 1'b0;
	endtask

	// Let the block drain before touching the registers.
	task automatic wait_idle();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_phase(input int count, input int restart_odds);
		send_request(1'b1);
		for (int i = 0; i < count; i++) begin
			send_request($urandom_range(1, 1000) <= restart_odds);
		end
		wait_idle();
	endtask

	task automatic set_grid(input logic [31:0] w, input logic [31:0] r);
		write_reg(CFG_GRID_WIDTH, w);
		write_reg(CFG_GRID_ROWS, r);
	endtask

	// Pick random register values, mostly small grids with now and then an extreme.
	task automatic random_setup();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			set_grid($urandom_range(0, 2), $urandom_range(3, 50));
		end else if (pick == 1) begin
			set_grid($urandom_range(1025, 2047), $urandom_range(3, 5));
		end else if (pick == 2) begin
			set_grid($urandom, 16'hFFFF);
		end else begin
			set_grid($urandom_range(3, 24), $urandom_range(0, 40));
		end
		write_reg(CFG_X_STEP, $urandom_range(0, 3) == 0 ? $urandom :
			$urandom_range(1, 32'h0002_0000));
		write_reg(CFG_T_STEP_SQ, $urandom_range(0, 3) == 0 ? $urandom :
			$urandom_range(0, 32'h0010_0000));
		write_reg(CFG_SOURCE_RATE, $urandom_range(0, 3) == 0 ? $urandom :
			$urandom_range(0, 32'h0004_0000));
		write_reg(CFG_X_OFFSET, $urandom_range(0, 3) == 0 ? $urandom :
			32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000));
		write_reg(CFG_T_OFFSET, $urandom_range(0, 3) == 0 ? $urandom :
			32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000));
	endtask

	initial begin
		arst_n = 1'b0;
		write_enable = 1'b0;
		write_index = '0;
		write_data = '0;
		req_valid = 1'b0;
		restart = 1'b0;
		calm = 1'b0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: reset values, smallest grid, degenerate widths, extremes.
		run_phase(4, 0);
		set_grid(3, 3);
		write_reg(CFG_X_STEP, 32'h7FFF_FFFF);
		write_reg(CFG_T_STEP_SQ, 32'h7FFF_FFFF);
		write_reg(CFG_SOURCE_RATE, 32'd0);
		write_reg(CFG_X_OFFSET, 32'h8000_0000);
		write_reg(CFG_T_OFFSET, 32'h7FFF_FFFF);
		run_phase(3, 0);
		set_grid(2, 10);
		run_phase(2, 0);
		set_grid(2047, 4);
		write_reg(CFG_SOURCE_RATE, 32'h7FFF_FFFF);
		write_reg(CFG_T_OFFSET, 32'h0);
		write_reg(CFG_X_OFFSET, 32'h0);
		run_phase(4, 0);
		// Narrower width while a row is open, without a restart.
		set_grid(12, 30);
		write_reg(CFG_SOURCE_RATE, 32'h0001_0000);
		write_reg(CFG_X_STEP, 32'h0000_8000);
		write_reg(CFG_T_STEP_SQ, 32'h0004_0000);
		run_phase(5, 0);
		write_reg(CFG_GRID_WIDTH, 5);
		send_request(1'b0);
		send_request(1'b0);
		wait_idle();

		// Random part; the last phases run with no random stalls or request gaps.
		for (int p = 0; p < 16; p++) begin
			calm = (p >= 13);
			random_setup();
			run_phase($urandom_range(90, 150), 15);
		end

		if (errors == 0) begin
			$display("wave_1d_fdtd_stencil: match");
		end else begin
			$display("wave_1d_fdtd_stencil: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/wfs_pkg.sv
design/wfs_ricker.sv
design/wfs_front.sv
design/wfs_queue.sv
design/wfs_back.sv
design/wave_1d_fdtd_stencil.sv
verif/wave_1d_fdtd_stencil_checker.sv
verif/wave_1d_fdtd_stencil_tb.sv
